// ----- rtl/core/ggba_pkg.sv -----
// Shared types and constants for the grid binning aggregator.
package ggba_pkg;

   localparam int unsigned TableEntries = 32;
   localparam int unsigned IdxW = $clog2(TableEntries);
   localparam logic signed [31:0] LatLimit = 32'sd900000000;
   localparam logic signed [31:0] LonLimit = 32'sd1800000000;
   localparam logic [1:0] AddrCellSize = 2'd0;
   localparam logic [1:0] AddrThreshold = 2'd1;

   typedef struct packed {
      logic        action;
      logic [31:0] latitude;
      logic [31:0] longitude;
      logic [31:0] speed;
   } req_type;

   typedef struct packed {
      logic        is_summary;
      logic        status;
      logic [31:0] cell_x;
      logic [30:0] cell_y;
      logic [33:0] center_lon;
      logic [33:0] center_lat;
      logic [31:0] event_count;
      logic [31:0] anomaly_count;
      logic [31:0] avg_speed;
      logic [30:0] max_speed;
      logic [31:0] invalid_count;
      logic [5:0]  cell_total;
   } rsp_type;

   // Classified work passed from the front end to the back end.
   typedef struct packed {
      logic        flush;
      logic        valid_pos;
      logic        anomaly;
      logic [31:0] lon_off;
      logic [30:0] lat_off;
      logic [31:0] speed;
   } work_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_FIND, ST_UPDATE, ST_SORT, ST_EMIT_MUL, ST_EMIT_DIV,
      ST_EMIT_OUT, ST_SUMMARY, ST_CLEAR
   } state_type;

   function automatic logic [31:0] inc_sat(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

endpackage

// ----- rtl/core/ggba_front.sv -----
// Front end: accepts items, checks the position range and classifies events.
module ggba_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  ggba_pkg::req_type    item,
   input  logic [31:0]          threshold,
   output logic                 work_valid,
   input  logic                 work_take,
   output ggba_pkg::work_type   work
);
   // Two-entry queue toward the back end.
   ggba_pkg::work_type q_ff [2];
   logic       wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   ggba_pkg::work_type w;
   logic signed [31:0] lat, lon;
   logic acc, take;

   assign lat = signed'(item.latitude);
   assign lon = signed'(item.longitude);
   assign full = (cnt_ff == 2'd2);
   assign acc = push && !full;
   assign work_valid = (cnt_ff != 2'd0);
   assign take = work_take && work_valid;
   assign work = q_ff[rd_ff];

   always_comb begin
      logic [32:0] lo;
      logic [31:0] la;
      lo = 33'(signed'(lon)) + 33'(ggba_pkg::LonLimit);
      la = lat + ggba_pkg::LatLimit;
      w.flush = item.action;
      w.valid_pos = (lat >= -ggba_pkg::LatLimit) && (lat <= ggba_pkg::LatLimit) &&
                    (lon >= -ggba_pkg::LonLimit) && (lon <= ggba_pkg::LonLimit);
      w.anomaly = signed'(item.speed) > signed'(threshold);
      w.lon_off = lo[31:0];
      w.lat_off = la[30:0];
      w.speed = item.speed;
   end

   always_comb begin
      wr_in = acc ? !wr_ff : wr_ff;
      rd_in = take ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(acc) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (acc) q_ff[wr_ff] <= w;
   end
endmodule

// ----- rtl/core/ggba_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, 64 by 32 bits.
module ggba_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] sh, df;

   assign done = done_ff;
   assign quotient = q_ff;

   always_comb begin
      sh = {r_ff[31:0], q_ff[63]};
      df = sh - {1'b0, d_ff};
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; n_in = 7'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!df[32]) begin
            r_in = df; q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = sh; q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff + 7'd1;
         if (n_ff == 7'd63) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
   end
endmodule

// ----- rtl/core/ggba_back.sv -----
// Back end: bins events into the cell table and emits a sorted batch report.
module ggba_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 work_valid,
   output logic                 work_take,
   input  ggba_pkg::work_type   work,
   input  logic [31:0]          cell_size,
   output logic                 out_valid,
   input  logic                 out_take,
   output ggba_pkg::rsp_type    out_item
);
   localparam int unsigned N = ggba_pkg::TableEntries;
   localparam int unsigned IW = ggba_pkg::IdxW;

   ggba_pkg::state_type st_ff, st_in;
   logic [N-1:0]  vld_ff, vld_in, done_ff, done_in;
   logic [31:0]   ex_ff [N];
   logic [30:0]   ey_ff [N];
   logic [31:0]   ec_ff [N];
   logic [63:0]   es_ff [N];
   logic [30:0]   em_ff [N];
   logic [31:0]   ea_ff [N];
   logic [31:0]   bev_ff, bev_in, binv_ff, binv_in, ban_ff, ban_in;
   logic          ovf_ff, ovf_in;
   logic [IW-1:0] sel_ff, sel_in;
   logic [IW:0]   scan_ff, scan_in;
   logic          hit_ff, hit_in, free_ff, free_in;
   logic [IW-1:0] hidx_ff, hidx_in, fidx_ff, fidx_in;
   logic [62:0]   best_ff, best_in;
   logic          bfound_ff, bfound_in;
   logic [31:0]   x_ff, x_in;
   logic [30:0]   y_ff, y_in;
   logic          phase_ff, phase_in;
   logic [5:0]    ncell_ff, ncell_in;
   logic [33:0]   clon_ff, clon_in, clat_ff, clat_in;
   logic [31:0]   size;
   ggba_pkg::rsp_type o_ff, o_in;
   logic          ov_ff, ov_in;
   logic          dstart, ddone, neg;
   logic [63:0]   dnd, dq, mag;
   logic [31:0]   dvs;
   logic          upd, alloc;
   logic [IW-1:0] slot;

   assign size = (cell_size == '0) ? 32'd1 : cell_size;
   assign out_valid = ov_ff;
   assign out_item = o_ff;

   ggba_div u_div (.clock, .reset, .start(dstart), .dividend(dnd), .divisor(dvs),
      .done(ddone), .quotient(dq));

   // Divider operands: cell binning in event mode, speed average in emit mode.
   // The longitude pass starts from idle, the latitude pass from the divide state.
   always_comb begin
      mag = es_ff[sel_ff][63] ? -es_ff[sel_ff] : es_ff[sel_ff];
      neg = es_ff[sel_ff][63];
      if (st_ff == ggba_pkg::ST_EMIT_MUL) begin
         dnd = mag;
         dvs = (ec_ff[sel_ff] == '0) ? 32'd1 : ec_ff[sel_ff];
      end else begin
         dnd = (st_ff == ggba_pkg::ST_DIV) ? {33'd0, work.lat_off} : {32'd0, work.lon_off};
         dvs = size;
      end
   end

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ggba_pkg::ST_IDLE:
            if (work_valid) begin
               if (work.flush) st_in = ovf_ff ? ggba_pkg::ST_SUMMARY : ggba_pkg::ST_SORT;
               else if (work.valid_pos) st_in = ggba_pkg::ST_DIV;
            end
         ggba_pkg::ST_DIV:      if (ddone && phase_ff) st_in = ggba_pkg::ST_FIND;
         ggba_pkg::ST_FIND:     if (scan_ff == IW'(N-1) + 1) st_in = ggba_pkg::ST_UPDATE;
         ggba_pkg::ST_UPDATE:   st_in = ggba_pkg::ST_IDLE;
         ggba_pkg::ST_SORT:
            if (scan_ff == IW'(N-1) + 1)
               st_in = bfound_ff ? ggba_pkg::ST_EMIT_MUL : ggba_pkg::ST_SUMMARY;
         ggba_pkg::ST_EMIT_MUL: st_in = ggba_pkg::ST_EMIT_DIV;
         ggba_pkg::ST_EMIT_DIV: if (ddone) st_in = ggba_pkg::ST_EMIT_OUT;
         ggba_pkg::ST_EMIT_OUT: if (!ov_ff) st_in = ggba_pkg::ST_SORT;
         ggba_pkg::ST_SUMMARY:  if (!ov_ff) st_in = ggba_pkg::ST_CLEAR;
         ggba_pkg::ST_CLEAR:    st_in = ggba_pkg::ST_IDLE;
         default:               st_in = ggba_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      logic [62:0] key;
      logic [63:0] avg;
      logic [65:0] cl;
      work_take = 1'b0; dstart = 1'b0;
      vld_in = vld_ff; done_in = done_ff;
      bev_in = bev_ff; binv_in = binv_ff; ban_in = ban_ff; ovf_in = ovf_ff;
      sel_in = sel_ff; scan_in = scan_ff;
      hit_in = hit_ff; free_in = free_ff; hidx_in = hidx_ff; fidx_in = fidx_ff;
      best_in = best_ff; bfound_in = bfound_ff; x_in = x_ff; y_in = y_ff;
      phase_in = phase_ff; ncell_in = ncell_ff; clon_in = clon_ff; clat_in = clat_ff;
      o_in = o_ff; ov_in = ov_ff && !out_take;
      upd = 1'b0; alloc = 1'b0; slot = hidx_ff;
      key = '0; avg = '0; cl = '0;
      unique case (st_ff)
         ggba_pkg::ST_IDLE: begin
            if (work_valid) begin
               if (work.flush) begin
                  work_take = 1'b1;
                  scan_in = '0; bfound_in = 1'b0; ncell_in = '0; done_in = '0;
               end else begin
                  bev_in = ggba_pkg::inc_sat(bev_ff);
                  if (!work.valid_pos) begin
                     binv_in = ggba_pkg::inc_sat(binv_ff);
                     work_take = 1'b1;
                  end else begin
                     if (work.anomaly) ban_in = ggba_pkg::inc_sat(ban_ff);
                     dstart = 1'b1; phase_in = 1'b0;
                  end
               end
            end
         end
         ggba_pkg::ST_DIV: begin
            if (ddone) begin
               if (!phase_ff) begin
                  x_in = dq[31:0]; phase_in = 1'b1; dstart = 1'b1;
               end else begin
                  y_in = dq[30:0];
                  scan_in = '0; hit_in = 1'b0; free_in = 1'b0;
               end
            end
         end
         ggba_pkg::ST_FIND: begin
            if (scan_ff != IW'(N-1) + 1) begin
               if (vld_ff[scan_ff[IW-1:0]] && ex_ff[scan_ff[IW-1:0]] == x_ff &&
                   ey_ff[scan_ff[IW-1:0]] == y_ff && !hit_ff) begin
                  hit_in = 1'b1; hidx_in = scan_ff[IW-1:0];
               end
               if (!vld_ff[scan_ff[IW-1:0]] && !free_ff) begin
                  free_in = 1'b1; fidx_in = scan_ff[IW-1:0];
               end
               scan_in = scan_ff + 1'b1;
            end
         end
         ggba_pkg::ST_UPDATE: begin
            work_take = 1'b1;
            if (hit_ff) begin
               upd = 1'b1; slot = hidx_ff;
            end else if (free_ff) begin
               upd = 1'b1; alloc = 1'b1; slot = fidx_ff; vld_in[fidx_ff] = 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
         ggba_pkg::ST_SORT: begin
            // Linear scan for the smallest key not yet emitted.
            if (scan_ff != IW'(N-1) + 1) begin
               key = {ex_ff[scan_ff[IW-1:0]], ey_ff[scan_ff[IW-1:0]]};
               if (vld_ff[scan_ff[IW-1:0]] && !done_ff[scan_ff[IW-1:0]] &&
                   (!bfound_ff || key < best_ff)) begin
                  bfound_in = 1'b1; best_in = key; sel_in = scan_ff[IW-1:0];
               end
               scan_in = scan_ff + 1'b1;
            end
         end
         ggba_pkg::ST_EMIT_MUL: begin
            dstart = 1'b1;
            cl = 66'(ex_ff[sel_ff]) * 66'(size) + 66'(size >> 1) - 66'(ggba_pkg::LonLimit);
            clon_in = cl[33:0];
            cl = 66'(ey_ff[sel_ff]) * 66'(size) + 66'(size >> 1) - 66'(ggba_pkg::LatLimit);
            clat_in = cl[33:0];
         end
         ggba_pkg::ST_EMIT_DIV: ;
         ggba_pkg::ST_EMIT_OUT: begin
            if (!ov_ff) begin
               avg = neg ? -dq : dq;
               o_in = '0;
               o_in.cell_x = ex_ff[sel_ff];
               o_in.cell_y = ey_ff[sel_ff];
               o_in.center_lon = clon_ff;
               o_in.center_lat = clat_ff;
               o_in.event_count = ec_ff[sel_ff];
               o_in.anomaly_count = ea_ff[sel_ff];
               if (!neg && dq > 64'h7FFFFFFF) o_in.avg_speed = 32'h7FFFFFFF;
               else if (neg && dq > 64'h80000000) o_in.avg_speed = 32'h80000000;
               else o_in.avg_speed = avg[31:0];
               o_in.max_speed = em_ff[sel_ff];
               ov_in = 1'b1;
               done_in[sel_ff] = 1'b1;
               ncell_in = ncell_ff + 6'd1;
               scan_in = '0; bfound_in = 1'b0;
            end
         end
         ggba_pkg::ST_SUMMARY: begin
            if (!ov_ff) begin
               o_in = '0;
               o_in.is_summary = 1'b1;
               o_in.status = ovf_ff;
               o_in.event_count = bev_ff;
               o_in.anomaly_count = ban_ff;
               o_in.invalid_count = binv_ff;
               o_in.cell_total = ncell_ff;
               ov_in = 1'b1;
            end
         end
         ggba_pkg::ST_CLEAR: begin
            vld_in = '0; bev_in = '0; binv_in = '0; ban_in = '0; ovf_in = 1'b0;
         end
         default: ;
      endcase
   end

   // Table entry update for a binned event.
   always_ff @(posedge clock) begin
      logic [63:0] s0, sx, sn;
      logic [30:0] m0;
      logic [31:0] c0, a0;
      if (upd) begin
         s0 = alloc ? 64'd0 : es_ff[slot];
         m0 = alloc ? 31'd0 : em_ff[slot];
         c0 = alloc ? 32'd0 : ec_ff[slot];
         a0 = alloc ? 32'd0 : ea_ff[slot];
         sx = {{32{work.speed[31]}}, work.speed};
         sn = s0 + sx;
         if (!s0[63] && !sx[63] && sn[63]) sn = 64'h7FFFFFFFFFFFFFFF;
         else if (s0[63] && sx[63] && !sn[63]) sn = 64'h8000000000000000;
         ex_ff[slot] <= x_ff;
         ey_ff[slot] <= y_ff;
         ec_ff[slot] <= ggba_pkg::inc_sat(c0);
         es_ff[slot] <= sn;
         if (!work.speed[31] && work.speed[30:0] > m0) em_ff[slot] <= work.speed[30:0];
         else em_ff[slot] <= m0;
         ea_ff[slot] <= work.anomaly ? ggba_pkg::inc_sat(a0) : a0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ggba_pkg::ST_IDLE;
         vld_ff <= '0; done_ff <= '0;
         bev_ff <= '0; binv_ff <= '0; ban_ff <= '0; ovf_ff <= 1'b0;
         ov_ff <= 1'b0;
         scan_ff <= '0; ncell_ff <= '0; phase_ff <= 1'b0;
         hit_ff <= 1'b0; free_ff <= 1'b0; bfound_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         vld_ff <= vld_in; done_ff <= done_in;
         bev_ff <= bev_in; binv_ff <= binv_in; ban_ff <= ban_in; ovf_ff <= ovf_in;
         ov_ff <= ov_in;
         scan_ff <= scan_in; ncell_ff <= ncell_in; phase_ff <= phase_in;
         hit_ff <= hit_in; free_ff <= free_in; bfound_ff <= bfound_in;
      end
      sel_ff <= sel_in; hidx_ff <= hidx_in; fidx_ff <= fidx_in;
      best_ff <= best_in; x_ff <= x_in; y_ff <= y_in;
      clon_ff <= clon_in; clat_ff <= clat_in; o_ff <= o_in;
   end
endmodule

// ----- rtl/core/geo_grid_binning_aggregator.sv -----
// Geographic grid binning aggregator with a telemetry queue and a report register.
// An event whose position is in range takes two passes of the shared
// radix-2 divider (64 steps each) to produce the cell indices, then a scan
// of the cell table finds a match or a free entry. Out-of-range events are
// only counted as invalid. An end-of-batch item emits each cell after a sort
// scan and a 64-step average division (no cells if the table overflowed),
// then a summary item, and clears the batch. A two-entry queue takes new
// items while the back end works.
module geo_grid_binning_aggregator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  ggba_pkg::req_type   req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output ggba_pkg::rsp_type   rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   logic [31:0] csize_ff, csize_in, thr_ff, thr_in;
   logic wv, wt, ov;
   ggba_pkg::work_type w;

   assign pready = 1'b1;
   assign rsp_empty = !ov;

   always_comb begin
      csize_in = csize_ff; thr_in = thr_ff;
      if (psel && penable && pwrite) begin
         if (paddr[2] == 1'b0 && paddr[1:0] == 2'b00) csize_in = pwdata;
         if (paddr[2] == 1'b1 && paddr[1:0] == 2'b00) thr_in = pwdata;
      end
      prdata = (paddr[2] == 1'b1) ? thr_ff : csize_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csize_ff <= 32'd10000000;
         thr_ff <= 32'd30000;
      end else begin
         csize_ff <= csize_in;
         thr_ff <= thr_in;
      end
   end

   ggba_front u_front (.clock, .reset, .push(req_push), .full(req_full), .item(req_data),
      .threshold(thr_ff), .work_valid(wv), .work_take(wt), .work(w));

   ggba_back u_back (.clock, .reset, .work_valid(wv), .work_take(wt), .work(w),
      .cell_size(csize_ff), .out_valid(ov), .out_take(rsp_pop), .out_item(rsp_data));

   a_empty_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty) else $error("result dropped");
   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data)) else $error("result changed");
endmodule
